// ----- design/lrg_pkg.sv -----
// Package: shared widths, codes, reset values and controller/datapath types.
`timescale 1ns / 1ps

package lrg_pkg;

   localparam int WORD_W     = 31;
   localparam int PROD_W     = 2 * WORD_W;
   localparam int ACTION_W   = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int RED_STEPS  = PROD_W;
   localparam int CNT_W      = $clog2(RED_STEPS);

   localparam logic [CSR_ADDR_W-1:0] CSR_MULTIPLIER = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_MODULUS    = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_SEED       = CSR_ADDR_W'(2);

   localparam logic [WORD_W-1:0] MULTIPLIER_RST = WORD_W'(444555666);
   localparam logic [WORD_W-1:0] MODULUS_RST    = WORD_W'(2147483647);
   localparam logic [WORD_W-1:0] SEED_RST       = WORD_W'(1234567);

   typedef enum logic [ACTION_W-1:0] {
      ACT_RAW      = 2'd0,
      ACT_FRACTION = 2'd1,
      ACT_BOUNDED  = 2'd2,
      ACT_REWIND   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MUL_STEP,
      MUL_HI,
      MUL_LO
   } mul_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED,
      ST_COMMIT,
      ST_SC_HI,
      ST_SC_LO,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       take_req;
      logic       load_seed;
      logic       mul_load;
      mul_op_type mul_op;
      logic       red_init;
      logic       red_step;
      logic       commit;
      logic       out_load;
      action_type out_action;
   } cmd_type;

endpackage

// ----- design/lrg_req_if.sv -----
// Interface: request channel carrying action and bound.
`timescale 1ns / 1ps

interface lrg_req_if;
   logic                         valid;
   logic                         ready;
   logic [lrg_pkg::ACTION_W-1:0] action;
   logic [lrg_pkg::WORD_W-1:0]   bound;

   modport source (output valid, output action, output bound, input ready);
   modport sink   (input valid, input action, input bound, output ready);
endinterface

// ----- design/lrg_rsp_if.sv -----
// Interface: response channel carrying raw value, fraction and bounded value.
`timescale 1ns / 1ps

interface lrg_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lrg_pkg::WORD_W-1:0] raw_value;
   logic [lrg_pkg::PROD_W-1:0] fraction;
   logic [lrg_pkg::WORD_W-1:0] bounded_value;

   modport source (output valid, output raw_value, output fraction, output bounded_value,
                   input ready);
   modport sink   (input valid, input raw_value, input fraction, input bounded_value,
                   output ready);
endinterface

// ----- design/lrg_datapath.sv -----
// Datapath: config registers, generator state, shared multiplier, modulo reducer, outputs.
`timescale 1ns / 1ps

module lrg_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  lrg_pkg::cmd_type               cmd,
   input  logic [lrg_pkg::WORD_W-1:0]     req_bound,
   input  logic                           csr_we,
   input  logic [lrg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lrg_pkg::WORD_W-1:0]     csr_data,
   output logic [lrg_pkg::WORD_W-1:0]     raw_value,
   output logic [lrg_pkg::PROD_W-1:0]     fraction,
   output logic [lrg_pkg::WORD_W-1:0]     bounded_value
);

   localparam int W = lrg_pkg::WORD_W;
   localparam int P = lrg_pkg::PROD_W;

   logic [W-1:0] mult_ff, mult_in;
   logic [W-1:0] modulus_ff, modulus_in;
   logic [W-1:0] seed_ff, seed_in;
   logic [W-1:0] cv_ff, cv_in;

   logic [W-1:0] bound_ff, bound_in;
   logic [P-1:0] prod_ff, prod_in;
   logic [P-1:0] hiprod_ff, hiprod_in;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] draw_hi_ff, draw_hi_in;
   logic [W-1:0] draw_lo_ff, draw_lo_in;
   logic [W-1:0] raw_ff, raw_in;
   logic [P-1:0] frac_ff, frac_in;
   logic [W-1:0] bnd_ff, bnd_in;

   logic [W-1:0] mul_a, mul_b;
   logic [P-1:0] product;
   logic [W:0]   red_trial, red_mod, red_diff;
   logic [W-1:0] draw;
   logic [P:0]   mid;
   logic [W-1:0] bsum;

   always_comb begin
      unique case (cmd.mul_op)
         lrg_pkg::MUL_STEP: begin
            mul_a = cv_ff;
            mul_b = mult_ff;
         end
         lrg_pkg::MUL_HI: begin
            mul_a = draw_hi_ff;
            mul_b = bound_ff;
         end
         lrg_pkg::MUL_LO: begin
            mul_a = draw_lo_ff;
            mul_b = bound_ff;
         end
         default: begin
            mul_a = cv_ff;
            mul_b = mult_ff;
         end
      endcase
   end

   assign product   = P'(mul_a) * P'(mul_b);
   assign red_trial = {rem_ff, prod_ff[P-1]};
   assign red_mod   = {1'b0, modulus_ff};
   assign red_diff  = red_trial - red_mod;
   assign draw      = (rem_ff == {W{1'b1}}) ? '0 : rem_ff;
   assign mid       = {1'b0, hiprod_ff[W-1:0], {W{1'b0}}} + {1'b0, prod_ff};
   assign bsum      = hiprod_ff[P-1:W] + W'(mid[P]);

   always_comb begin
      mult_in    = mult_ff;
      modulus_in = modulus_ff;
      seed_in    = seed_ff;
      cv_in      = cv_ff;
      if (csr_we) begin
         unique case (csr_addr)
            lrg_pkg::CSR_MULTIPLIER: mult_in    = csr_data;
            lrg_pkg::CSR_MODULUS:    modulus_in = csr_data;
            lrg_pkg::CSR_SEED:       seed_in    = csr_data;
            default: ;
         endcase
      end
      if (cmd.load_seed) begin
         cv_in = seed_ff;
      end else if (cmd.commit) begin
         cv_in = rem_ff;
      end
   end

   always_comb begin
      bound_in   = cmd.take_req ? req_bound : bound_ff;
      prod_in    = prod_ff;
      hiprod_in  = hiprod_ff;
      rem_in     = rem_ff;
      draw_hi_in = draw_hi_ff;
      draw_lo_in = draw_lo_ff;
      raw_in     = raw_ff;
      frac_in    = frac_ff;
      bnd_in     = bnd_ff;
      if (cmd.mul_load) begin
         prod_in = product;
         if (cmd.mul_op == lrg_pkg::MUL_LO) begin
            hiprod_in = prod_ff;
         end
      end else if (cmd.red_step) begin
         prod_in = {prod_ff[P-2:0], 1'b0};
      end
      if (cmd.red_init) begin
         rem_in = '0;
      end else if (cmd.red_step) begin
         rem_in = (red_trial >= red_mod) ? red_diff[W-1:0] : red_trial[W-1:0];
      end
      if (cmd.commit) begin
         draw_hi_in = draw;
         draw_lo_in = draw_hi_ff;
      end
      if (cmd.out_load) begin
         raw_in  = draw_hi_ff;
         frac_in = (cmd.out_action == lrg_pkg::ACT_RAW) ? '0 : {draw_hi_ff, draw_lo_ff};
         bnd_in  = (cmd.out_action == lrg_pkg::ACT_BOUNDED) ? bsum : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff    <= lrg_pkg::MULTIPLIER_RST;
         modulus_ff <= lrg_pkg::MODULUS_RST;
         seed_ff    <= lrg_pkg::SEED_RST;
         cv_ff      <= lrg_pkg::SEED_RST;
      end else begin
         mult_ff    <= mult_in;
         modulus_ff <= modulus_in;
         seed_ff    <= seed_in;
         cv_ff      <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      bound_ff   <= bound_in;
      prod_ff    <= prod_in;
      hiprod_ff  <= hiprod_in;
      rem_ff     <= rem_in;
      draw_hi_ff <= draw_hi_in;
      draw_lo_ff <= draw_lo_in;
      raw_ff     <= raw_in;
      frac_ff    <= frac_in;
      bnd_ff     <= bnd_in;
   end

   assign raw_value     = raw_ff;
   assign fraction      = frac_ff;
   assign bounded_value = bnd_ff;

endmodule

// ----- design/lrg_controller.sv -----
// Controller: sequences steps, reduction, scaling and the response register.
`timescale 1ns / 1ps

module lrg_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [lrg_pkg::ACTION_W-1:0] req_action,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lrg_pkg::cmd_type             cmd
);

   lrg_pkg::state_type  state_ff, state_in;
   lrg_pkg::action_type action_ff, action_in;
   logic [lrg_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic second_ff, second_in;
   logic rsp_valid_ff, rsp_valid_in;
   lrg_pkg::action_type req_act;

   assign req_act = lrg_pkg::action_type'(req_action);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrg_pkg::ST_IDLE;
         action_ff    <= lrg_pkg::ACT_RAW;
         cnt_ff       <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         action_ff    <= action_in;
         cnt_ff       <= cnt_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      cnt_in         = cnt_ff;
      second_in      = second_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.mul_op     = lrg_pkg::MUL_STEP;
      cmd.out_action = action_ff;
      unique case (state_ff)
         lrg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_act == lrg_pkg::ACT_REWIND) begin
                  cmd.load_seed = 1'b1;
               end else begin
                  cmd.take_req = 1'b1;
                  action_in    = req_act;
                  second_in    = 1'b0;
                  state_in     = lrg_pkg::ST_MUL;
               end
            end
         end
         lrg_pkg::ST_MUL: begin
            cmd.mul_load = 1'b1;
            cmd.red_init = 1'b1;
            cnt_in       = '0;
            state_in     = lrg_pkg::ST_RED;
         end
         lrg_pkg::ST_RED: begin
            cmd.red_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == lrg_pkg::CNT_W'(lrg_pkg::RED_STEPS - 1)) begin
               state_in = lrg_pkg::ST_COMMIT;
            end
         end
         lrg_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (action_ff != lrg_pkg::ACT_RAW && !second_ff) begin
               second_in = 1'b1;
               state_in  = lrg_pkg::ST_MUL;
            end else if (action_ff == lrg_pkg::ACT_BOUNDED) begin
               state_in = lrg_pkg::ST_SC_HI;
            end else begin
               state_in = lrg_pkg::ST_FINISH;
            end
         end
         lrg_pkg::ST_SC_HI: begin
            cmd.mul_load = 1'b1;
            cmd.mul_op   = lrg_pkg::MUL_HI;
            state_in     = lrg_pkg::ST_SC_LO;
         end
         lrg_pkg::ST_SC_LO: begin
            cmd.mul_load = 1'b1;
            cmd.mul_op   = lrg_pkg::MUL_LO;
            state_in     = lrg_pkg::ST_FINISH;
         end
         lrg_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = lrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

// ----- design/lehmer_random_generator.sv -----
// Top level: Lehmer generator with raw, fraction, bounded and rewind requests.
//
// Requests arrive on req_ch (action, bound); results leave on rsp_ch (raw_value,
// fraction, bounded_value). The user must write registers multiplier, modulus
// and seed through csr_we/csr_addr/csr_data only while the block is idle; the
// block itself does not enforce it. Each step multiplies the state by the
// multiplier and reduces the 62-bit product by a restoring shift-subtract unit
// at one bit per cycle. Raw takes one step, fraction two, and bounded two steps
// plus two extra multiplies for the scaling. A rewind gives no result. One
// request is in work at a time; a new request is taken once the previous one
// has reached the result register. When the receiver stalls, the finished
// result holds on rsp_ch, the next request is still taken and computed, and it
// waits before loading until the first leaves. Synchronous reset restores the
// register reset values, sets the state to the seed and empties the result
// register.
`timescale 1ns / 1ps

module lehmer_random_generator (
   input  logic                           clock,
   input  logic                           reset,
   lrg_req_if.sink                        req_ch,
   lrg_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [lrg_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lrg_pkg::WORD_W-1:0]     csr_data
);

   lrg_pkg::cmd_type cmd;
   logic             req_ready;
   logic             rsp_valid;

   lrg_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ch.ready),
      .cmd        (cmd)
   );

   lrg_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_bound     (req_ch.bound),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_data      (csr_data),
      .raw_value     (rsp_ch.raw_value),
      .fraction      (rsp_ch.fraction),
      .bounded_value (rsp_ch.bounded_value)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

// ----- design/lrg_checker.sv -----
// Checker: port-level assertions for the generator, bound to the top level.
`timescale 1ns / 1ps

module lrg_port_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [lrg_pkg::ACTION_W-1:0] req_action,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [lrg_pkg::WORD_W-1:0]   rsp_raw_value,
   input logic [lrg_pkg::PROD_W-1:0]   rsp_fraction,
   input logic [lrg_pkg::WORD_W-1:0]   rsp_bounded_value
);

   localparam int W = lrg_pkg::WORD_W;
   localparam int P = lrg_pkg::PROD_W;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_value)
         && $stable(rsp_fraction) && $stable(rsp_bounded_value))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action != lrg_pkg::ACT_REWIND |=> !req_ready)
      else $error("request taken while previous one still in work");

   a_frac_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fraction != '0 |-> rsp_fraction[P-1:W] == rsp_raw_value)
      else $error("fraction high half differs from raw value");

   a_draw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_raw_value != {W{1'b1}}
         && (rsp_bounded_value == '0 || rsp_fraction != '0))
      else $error("draw out of range or bounded value without fraction");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind lehmer_random_generator lrg_port_checker u_lrg_port_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_action        (req_ch.action),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_raw_value     (rsp_ch.raw_value),
   .rsp_fraction      (rsp_ch.fraction),
   .rsp_bounded_value (rsp_ch.bounded_value)
);
